### hw/rtl/dsf_pkg.sv
// Shared types and constants of the distance sample filter.
// Used by dsf_avg, the top level and the bench; depends on nothing.
package dsf_pkg;

   // filter_mode register codes
   typedef enum logic [1:0] {
      MODE_RAW    = 2'd0,
      MODE_AVG    = 2'd1,
      MODE_MEAN   = 2'd2,
      MODE_MEDIAN = 2'd3
   } filter_mode_type;

   // register indexes on the csr port
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_WEIGHT = 1'd1;

   localparam int WEIGHT_W = 9;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 9'd256;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 9'd205;

   // per-stage control that rides along with each word
   typedef struct packed {
      logic            valid;
      filter_mode_type mode;
   } stage_ctl_type;

   // update request to the running average unit
   typedef struct packed {
      logic                update;
      logic [WEIGHT_W-1:0] weight;
   } avg_ctl_type;

endpackage

### hw/rtl/dsf_cell.sv
// One window cell: holds a sample, hands it to the next cell on shift and
// ranks its own value against the whole window. Depends on no other file.
module dsf_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int WINDOW_LEN  = 5,
   parameter int CELL_IDX    = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    shift_en,
   input  logic [SAMPLE_BITS-1:0]                  shift_in,
   input  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0]  window_in,
   output logic [SAMPLE_BITS-1:0]                  value,
   output logic [WINDOW_LEN-1:0]                   below
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;

   always_comb begin
      value_in = shift_en ? shift_in : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   // below[j]: entry j sorts ahead of this cell (ties broken by position)
   always_comb begin
      for (int j = 0; j < WINDOW_LEN; j++) begin
         below[j] = (window_in[j] < value_ff) ||
                    ((window_in[j] == value_ff) && (j < CELL_IDX));
      end
   end

   assign value = value_ff;

endmodule

### hw/rtl/dsf_avg.sv
// Exponential running average in Q.8 fixed point, one update per cycle while ctl.update is set.
// Depends on dsf_pkg.
module dsf_avg #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dsf_pkg::avg_ctl_type     ctl,
   input  logic [SAMPLE_BITS-1:0]   sample,
   output logic [SAMPLE_BITS+7:0]   average
);

   localparam int AVG_W = SAMPLE_BITS + 8;
   localparam int ACC_W = SAMPLE_BITS + 18;

   logic [AVG_W-1:0]            avg_ff;
   logic [AVG_W-1:0]            avg_in;
   logic [dsf_pkg::WEIGHT_W-1:0] w_sat;
   logic [dsf_pkg::WEIGHT_W-1:0] w_new;
   logic [ACC_W-1:0]            acc;

   always_comb begin
      w_sat  = (ctl.weight > dsf_pkg::WEIGHT_ONE) ? dsf_pkg::WEIGHT_ONE : ctl.weight;
      w_new  = dsf_pkg::WEIGHT_ONE - w_sat;
      acc    = ACC_W'({sample, 8'd0}) * ACC_W'(w_new) + ACC_W'(avg_ff) * ACC_W'(w_sat);
      avg_in = ctl.update ? acc[AVG_W+7:8] : avg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else begin
         avg_ff <= avg_in;
      end
   end

   assign average = avg_ff;

endmodule

### hw/rtl/distance_sample_filter_unit.sv
// Distance sample filter, top level: window cell chain, running average,
// mean and median stages, output register. Depends on dsf_pkg, dsf_cell, dsf_avg.
//
// Takes one distance sample per word and returns one filtered word per sample,
// at a sustained rate of one word per cycle while the output is taken.
// Every sample shifts into a chain of WINDOW_LEN cells (cleared at reset, so
// early means and medians include zeros). filter_mode picks the result: raw
// sample, exponential running average (state updates only in that mode), the
// floor mean of the window, or the window median (lower median for an even
// length). Stage 1 is the cell chain plus the average register, stage 2 holds
// the window sum and the cell rank bits, stage 3 the reciprocal-multiply mean
// and the rank-selected median, then the output register. Each stage loads
// when it is empty or its successor moves, so a held output only stalls the
// input once the pipe behind it is full. The rate is set by the average
// update, a 9-bit multiply-accumulate that closes on itself each cycle.
// Configuration writes take effect on the next accepted word.
module distance_sample_filter_unit #(
   parameter int WINDOW_LEN  = 5,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,   // [SAMPLE_BITS-1:0] sample_in
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,   // [SAMPLE_BITS-1:0] filtered_out
   // configuration
   input  logic                              csr_we,
   input  logic [dsf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dsf_pkg::WEIGHT_W-1:0]      csr_wdata
);

   localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int IDX_BITS   = $clog2(WINDOW_LEN);
   localparam int SUM_W      = SAMPLE_BITS + IDX_BITS;
   localparam int RANK_W     = IDX_BITS;
   localparam int MID        = (WINDOW_LEN - 1) / 2;
   // floor(sum / WINDOW_LEN) == (sum * RECIP) >> MEAN_SHIFT for every sum < 2^SUM_W
   localparam int MEAN_SHIFT = SUM_W + IDX_BITS;
   localparam logic [63:0] RECIP64 =
      ((64'd1 << MEAN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
   localparam int RECIP_W    = SUM_W + 1;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
   localparam logic [RANK_W-1:0]  MID_RANK = RANK_W'(MID);

   // ---------------- configuration registers ----------------
   dsf_pkg::filter_mode_type      mode_ff, mode_in;
   logic [dsf_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;

   always_comb begin
      mode_in   = mode_ff;
      weight_in = weight_ff;
      if (csr_we) begin
         case (csr_index)
            dsf_pkg::CSR_FILTER_MODE:      mode_in   = dsf_pkg::filter_mode_type'(csr_wdata[1:0]);
            dsf_pkg::CSR_SMOOTHING_WEIGHT: weight_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= dsf_pkg::MODE_RAW;
         weight_ff <= dsf_pkg::WEIGHT_RESET;
      end else begin
         mode_ff   <= mode_in;
         weight_ff <= weight_in;
      end
   end

   // ---------------- flow control ----------------
   dsf_pkg::stage_ctl_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, free3, free2, free1, accept;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign free3      = !s3_ff.valid || out_free;
   assign free2      = !s2_ff.valid || free3;
   assign free1      = !s1_ff.valid || free2;
   assign req_tready = free1;
   assign accept     = req_tvalid && free1;

   logic [SAMPLE_BITS-1:0] sample;
   assign sample = req_tdata[SAMPLE_BITS-1:0];

   // ---------------- stage 1: cell chain and running average ----------------
   logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window;
   logic [WINDOW_LEN-1:0][WINDOW_LEN-1:0]  below;

   for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
      dsf_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .WINDOW_LEN  (WINDOW_LEN),
         .CELL_IDX    (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (accept),
         .shift_in  ((k == 0) ? sample : window[(k == 0) ? 0 : k-1]),
         .window_in (window),
         .value     (window[k]),
         .below     (below[k])
      );
   end

   dsf_pkg::avg_ctl_type      avg_ctl;
   logic [SAMPLE_BITS+7:0]    average;

   assign avg_ctl.update = accept && (mode_ff == dsf_pkg::MODE_AVG);
   assign avg_ctl.weight = weight_ff;

   dsf_avg #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_avg (
      .clock   (clock),
      .reset   (reset),
      .ctl     (avg_ctl),
      .sample  (sample),
      .average (average)
   );

   // newest sample sits in cell 0; average register holds this word's update
   logic [SAMPLE_BITS-1:0] raw1;
   assign raw1 = (s1_ff.mode == dsf_pkg::MODE_AVG) ? average[SAMPLE_BITS+7:8] : window[0];

   always_comb begin
      s1_in = s1_ff;
      if (free1) begin
         s1_in.valid = accept;
         s1_in.mode  = mode_ff;
      end
   end

   // ---------------- stage 2: window sum, rank bits ----------------
   logic [SUM_W-1:0]                       sum2_ff, sum2_in, win_sum;
   logic [WINDOW_LEN-1:0][WINDOW_LEN-1:0]  below2_ff, below2_in;
   logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] win2_ff, win2_in;
   logic [SAMPLE_BITS-1:0]                 raw2_ff, raw2_in;

   always_comb begin
      win_sum = '0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
         win_sum = win_sum + SUM_W'(window[k]);
      end
   end

   always_comb begin
      s2_in     = s2_ff;
      sum2_in   = sum2_ff;
      below2_in = below2_ff;
      win2_in   = win2_ff;
      raw2_in   = raw2_ff;
      if (free2) begin
         s2_in     = s1_ff;
         sum2_in   = win_sum;
         below2_in = below;
         win2_in   = window;
         raw2_in   = raw1;
      end
   end

   // ---------------- stage 3: mean and median ----------------
   logic [PROD_W-1:0]      mean_prod;
   logic [SAMPLE_BITS-1:0] mean3_ff, mean3_in, med3_ff, med3_in, med_sel;
   logic [SAMPLE_BITS-1:0] raw3_ff, raw3_in;
   logic [RANK_W-1:0]      rank [WINDOW_LEN];

   assign mean_prod = PROD_W'(sum2_ff) * PROD_W'(RECIP);

   always_comb begin
      med_sel = '0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
         rank[k] = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            rank[k] = rank[k] + RANK_W'(below2_ff[k][j]);
         end
         // ranks are a permutation, so exactly one cell matches
         if (rank[k] == MID_RANK) begin
            med_sel = med_sel | win2_ff[k];
         end
      end
   end

   always_comb begin
      s3_in    = s3_ff;
      mean3_in = mean3_ff;
      med3_in  = med3_ff;
      raw3_in  = raw3_ff;
      if (free3) begin
         s3_in    = s2_ff;
         mean3_in = mean_prod[MEAN_SHIFT +: SAMPLE_BITS];
         med3_in  = med_sel;
         raw3_in  = raw2_ff;
      end
   end

   // ---------------- output register ----------------
   logic [SAMPLE_BITS-1:0] out_ff, out_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in = s3_ff.valid;
         case (s3_ff.mode)
            dsf_pkg::MODE_MEAN:   out_in = mean3_ff;
            dsf_pkg::MODE_MEDIAN: out_in = med3_ff;
            default:              out_in = raw3_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '{valid: 1'b0, mode: dsf_pkg::MODE_RAW};
         s2_ff        <= '{valid: 1'b0, mode: dsf_pkg::MODE_RAW};
         s3_ff        <= '{valid: 1'b0, mode: dsf_pkg::MODE_RAW};
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum2_ff   <= sum2_in;
      below2_ff <= below2_in;
      win2_ff   <= win2_in;
      raw2_ff   <= raw2_in;
      mean3_ff  <= mean3_in;
      med3_ff   <= med3_in;
      raw3_ff   <= raw3_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_W'(out_ff);

   // ---------------- assertions ----------------
   // accepted word lands in the head cell and occupies stage 1
   a_head_cell: assert property (@(posedge clock) disable iff (reset)
      accept |=> (s1_ff.valid && window[0] == $past(sample)))
      else $error("accepted sample not in head cell");

   // average state moves only for words taken in average mode
   a_avg_hold: assert property (@(posedge clock) disable iff (reset)
      !avg_ctl.update |=> $stable(average))
      else $error("running average changed outside average mode");

   // a stage-3 word blocked by the output register is kept
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_ff.valid && !out_free) |=> (s3_ff.valid && $stable(raw3_ff)))
      else $error("stage 3 word lost under stall");

   // stage 1 cannot be refilled while it holds a blocked word
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && !free2) |-> !req_tready)
      else $error("input accepted over a held stage 1 word");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for distance_sample_filter_unit: streams samples in bursts,
// predicts every filtered word in-house and checks results in order.
// Depends on dsf_pkg and the RTL top level only.
module tb;
   import dsf_pkg::*;

   localparam int WIN        = 5;
   localparam int SB         = 16;
   localparam int DW         = ((SB + 7) / 8) * 8;
   // words stay accepted on some side well within this many cycles
   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 80;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DW-1:0]          req_tdata = '0;   // [15:0] sample_in
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DW-1:0]          rsp_tdata;        // [15:0] filtered_out
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [WEIGHT_W-1:0]    csr_wdata = '0;

   distance_sample_filter_unit #(.WINDOW_LEN(WIN), .SAMPLE_BITS(SB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Filter state as the bench sees it: window ring, Q.8 running average,
   // and the two registers.
   // ---------------------------------------------------------------------
   logic [SB-1:0]       win_q [WIN];
   int                  win_slot;
   logic [SB+7:0]       avg_q8;
   filter_mode_type     cur_mode;
   logic [WEIGHT_W-1:0] cur_weight;

   logic [SB-1:0] sample_q [$];     // words waiting for the driver
   logic [SB-1:0] filtered_q [$];   // filtered words still to come out

   int queued_cnt = 0;
   int in_cnt = 0;
   int out_cnt = 0;
   int mismatch_cnt = 0;
   int setting_cnt = 0;
   int stall_in_cnt = 0;   // cycles the block refused an offered word
   bit long_hold_done = 1'b0;

   // Filters one accepted sample and queues the word the block must return.
   function automatic void filter_sample(input logic [SB-1:0] smp);
      logic [SB-1:0]       srt [WIN];
      logic [SB-1:0]       v;
      logic [63:0]         acc;
      logic [63:0]         sum;
      logic [WEIGHT_W-1:0] w;
      logic [SB-1:0]       res;
      int                  j;
      win_q[win_slot] = smp;
      win_slot = (win_slot + 1) % WIN;
      case (cur_mode)
         MODE_AVG: begin
            // weights above one saturate, so the average just holds
            w = (cur_weight > WEIGHT_ONE) ? WEIGHT_ONE : cur_weight;
            acc = ({48'd0, smp} << 8) * (64'd256 - {55'd0, w})
                  + {40'd0, avg_q8} * {55'd0, w};
            avg_q8 = acc[SB+15:8];
            res = avg_q8[SB+7:8];
         end
         MODE_MEAN: begin
            sum = '0;
            for (int i = 0; i < WIN; i++) sum += {48'd0, win_q[i]};
            sum = sum / WIN;
            res = sum[SB-1:0];
         end
         MODE_MEDIAN: begin
            srt = win_q;
            for (int i = 1; i < WIN; i++) begin
               v = srt[i];
               j = i - 1;
               while (j >= 0 && srt[j] > v) begin
                  srt[j+1] = srt[j];
                  j--;
               end
               srt[j+1] = v;
            end
            res = srt[(WIN-1)/2];
         end
         default: res = smp;
      endcase
      filtered_q.push_back(res);
   endfunction

   // Samples: extremes, a cluster around a base (ties for the median), or anything.
   function automatic logic [SB-1:0] pick_sample(input logic [SB-1:0] base);
      int r;
      r = $urandom_range(0, 15);
      if (r < 2) return '0;
      if (r < 4) return '1;
      if (r < 8) return base + SB'($urandom_range(0, 6)) - SB'(3);
      return SB'($urandom());
   endfunction

   // Config writes happen only with the pipe empty; bench copy follows at once.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [WEIGHT_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FILTER_MODE) cur_mode = filter_mode_type'(val[1:0]);
      else cur_weight = val;
   endtask

   task automatic send(input logic [SB-1:0] smp);
      sample_q.push_back(smp);
      queued_cnt++;
   endtask

   // Sender pause: nothing new until every filtered word is back.
   task automatic wait_drained();
      while (in_cnt != queued_cnt || filtered_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of random length, random gaps; holds data while stalled.
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            filter_sample(req_tdata[SB-1:0]);
            in_cnt++;
         end
         if (req_tvalid && !req_tready) stall_in_cnt++;
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sample_q.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= DW'(sample_q.pop_front());
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  // a third of the bursts run straight into the next one
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready in a repeating window, random stalls outside it, and
   // one long hold-off that fills the pipe and backs up the input.
   // ---------------------------------------------------------------------
   int rx_cyc = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && in_cnt >= 400) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if ((rx_cyc % 96) < 32) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every accepted word against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [SB-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         out_cnt++;
         if (filtered_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("ERROR: unexpected word filtered_out=%h", rsp_tdata[SB-1:0]);
         end else begin
            want = filtered_q.pop_front();
            if (rsp_tdata[SB-1:0] !== want) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("ERROR: word %0d filtered_out expected %h got %h",
                           out_cnt, want, rsp_tdata[SB-1:0]);
            end
         end
      end
   end

   // Watchdog: too long without a word moving on either side.
   int idle_cyc = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cyc);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cyc <= idle_cyc + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: directed phases, then random phases with a fresh setting each.
   // ---------------------------------------------------------------------
   logic [SB-1:0] base;
   int            n;
   int            wsel;
   logic [WEIGHT_W-1:0] wval;

   initial begin
      for (int i = 0; i < WIN; i++) win_q[i] = '0;
      win_slot   = 0;
      avg_q8     = '0;
      cur_mode   = MODE_RAW;
      cur_weight = WEIGHT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // median with the window still holding reset zeros; upper wdata bits
      // set to check that only the mode bits are kept
      write_reg(CSR_FILTER_MODE, {7'h7E, MODE_MEDIAN});
      setting_cnt++;
      send(16'hFFFF); send(16'h1234); send(16'hFFFF); send(16'h0001);
      wait_drained();

      // mean: full-scale window, then a zero into it
      write_reg(CSR_FILTER_MODE, {7'h00, MODE_MEAN});
      setting_cnt++;
      repeat (5) send(16'hFFFF);
      send(16'h0000);
      wait_drained();

      // running average at the reset weight
      write_reg(CSR_FILTER_MODE, {7'h55, MODE_AVG});
      setting_cnt++;
      send(16'hFFFF); send(16'hFFFF); send(16'h0000);
      wait_drained();

      // weight zero: output tracks the sample
      write_reg(CSR_SMOOTHING_WEIGHT, 9'd0);
      setting_cnt++;
      send(16'h8000); send(16'h0001);
      wait_drained();

      // weight one: average holds
      write_reg(CSR_SMOOTHING_WEIGHT, WEIGHT_ONE);
      setting_cnt++;
      send(16'h7FFF); send(16'h0000);
      wait_drained();

      // weights above one saturate
      write_reg(CSR_SMOOTHING_WEIGHT, 9'h1FF);
      setting_cnt++;
      send(16'hFFFF);
      wait_drained();
      write_reg(CSR_SMOOTHING_WEIGHT, WEIGHT_ONE + 9'd1);
      setting_cnt++;
      send(16'h4321);
      wait_drained();

      // raw pass-through, alternating bit patterns
      write_reg(CSR_FILTER_MODE, {7'h7F, MODE_RAW});
      setting_cnt++;
      send(16'h0000); send(16'hFFFF); send(16'hAAAA); send(16'h5555);
      wait_drained();

      // random phases: each mode in turn, weight from the extremes or anywhere
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(CSR_FILTER_MODE,
                   {7'($urandom_range(0, 127)), filter_mode_type'(ph % 4)});
         wsel = $urandom_range(0, 9);
         case (wsel)
            0: wval = 9'd0;
            1: wval = 9'd1;
            2: wval = 9'd255;
            3: wval = WEIGHT_ONE;
            4: wval = WEIGHT_ONE + 9'd1;
            5: wval = 9'h1FF;
            default: wval = 9'($urandom_range(0, 511));
         endcase
         write_reg(CSR_SMOOTHING_WEIGHT, wval);
         setting_cnt++;
         base = SB'($urandom());
         n = $urandom_range(85, 115);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) base = SB'($urandom());
            send(pick_sample(base));
         end
         wait_drained();
      end

      if (filtered_q.size() != 0) mismatch_cnt += filtered_q.size();
      $display("run covered %0d sample words and %0d filtered words over %0d settings",
               in_cnt, out_cnt, setting_cnt);
      $display("all four modes, weights 0..511, input backpressure on %0d cycles",
               stall_in_cnt);
      if (mismatch_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatch_cnt);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_cell.sv
hw/rtl/dsf_avg.sv
hw/rtl/distance_sample_filter_unit.sv
tb/tb.sv
